/* hdl/lcdf_pkg.sv */
// Shared types, constants and the control store for the character LCD write formatter.
// Depends on nothing; every other file of the block imports it.
package lcdf_pkg;

  // Number formatting limits.
  localparam int MAX_DIGITS = 20;
  localparam int NUM_W      = 64;
  localparam int BCD_DIGITS = 20;
  localparam int IDX_W      = $clog2(BCD_DIGITS);
  localparam int CNT_W      = $clog2(NUM_W);

  // Configuration port geometry.
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  // Action codes of an input item.
  localparam logic [1:0] ACT_COMMAND = 2'd0;
  localparam logic [1:0] ACT_DATA    = 2'd1;
  localparam logic [1:0] ACT_CURSOR  = 2'd2;
  localparam logic [1:0] ACT_NUMBER  = 2'd3;

  // Cursor rows that produce a write.
  localparam logic [1:0] ROW_FIRST  = 2'd1;
  localparam logic [1:0] ROW_SECOND = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_BUS_EIGHT    = 2'd0;
  localparam logic [1:0] REG_NIBBLE_UPPER = 2'd1;
  localparam logic [1:0] REG_OTHER_HALF   = 2'd2;

  // Display constants.
  localparam logic [7:0] DDRAM_BASE  = 8'h80;
  localparam logic [7:0] ROW2_OFFSET = 8'd64;
  localparam logic [7:0] ASCII_ZERO  = 8'd48;

  typedef struct packed {
    logic       bus_eight_bit;
    logic       nibble_on_upper;
    logic [3:0] other_half_pins;
  } cfg_t;

  // Control store addresses.
  typedef enum logic [3:0] {
    UA_FETCH,
    UA_EMIT_HI,
    UA_EMIT_LO,
    UA_AFTER,
    UA_DEC_IDX,
    UA_DABBLE,
    UA_SCAN,
    UA_CLAMP,
    UA_DIGIT
  } ua_t;

  // Datapath operations.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_EMIT_HI,
    OP_EMIT_LO,
    OP_DABBLE,
    OP_SCAN,
    OP_CLAMP,
    OP_DIGIT,
    OP_DEC_IDX
  } op_t;

  typedef enum logic [1:0] {J_NEXT, J_GOTO, J_IF, J_DISPATCH} jump_t;

  typedef enum logic [1:0] {C_BUS8, C_FINAL, C_DABBLE_MORE, C_LEAD_ZERO} cond_t;

  typedef struct packed {
    op_t   op;
    jump_t jmp;
    cond_t cond;
    ua_t   target;
  } ucode_t;

  // Status the datapath returns to the sequencer.
  typedef struct packed {
    logic bus8;
    logic final_byte;
    logic dabble_more;
    logic lead_zero;
    logic slot_free;
  } dp_status_t;

  // Microprogram. A conditional jump goes to target when its condition holds,
  // else to the next step.
  function automatic ucode_t ucode_rom(ua_t addr);
    ucode_t cw;
    unique case (addr)
      UA_FETCH:   cw = '{OP_LOAD,    J_DISPATCH, C_BUS8,        UA_FETCH};
      UA_EMIT_HI: cw = '{OP_EMIT_HI, J_IF,       C_BUS8,        UA_AFTER};
      UA_EMIT_LO: cw = '{OP_EMIT_LO, J_NEXT,     C_BUS8,        UA_AFTER};
      UA_AFTER:   cw = '{OP_NONE,    J_IF,       C_FINAL,       UA_FETCH};
      UA_DEC_IDX: cw = '{OP_DEC_IDX, J_GOTO,     C_BUS8,        UA_DIGIT};
      UA_DABBLE:  cw = '{OP_DABBLE,  J_IF,       C_DABBLE_MORE, UA_DABBLE};
      UA_SCAN:    cw = '{OP_SCAN,    J_IF,       C_LEAD_ZERO,   UA_SCAN};
      UA_CLAMP:   cw = '{OP_CLAMP,   J_NEXT,     C_BUS8,        UA_FETCH};
      UA_DIGIT:   cw = '{OP_DIGIT,   J_GOTO,     C_BUS8,        UA_EMIT_HI};
      default:    cw = '{OP_NONE,    J_GOTO,     C_BUS8,        UA_FETCH};
    endcase
    return cw;
  endfunction

endpackage

/* hdl/lcdf_ifs.sv */
// Valid/ready channel interfaces for the request and bus-write channels.
// Depends on lcdf_pkg for the number width.
interface lcdf_in_if;
  import lcdf_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       action;
  logic [7:0]       byte_value;
  logic [1:0]       row_number;
  logic [7:0]       column_number;
  logic [NUM_W-1:0] number_value;

  modport source (output valid, action, byte_value, row_number, column_number, number_value,
                  input ready);
  modport sink   (input valid, action, byte_value, row_number, column_number, number_value,
                  output ready);
endinterface

interface lcdf_out_if;
  logic       valid;
  logic       ready;
  logic       reg_select;
  logic [7:0] port_value;
  logic       last;

  modport source (output valid, reg_select, port_value, last, input ready);
  modport sink   (input valid, reg_select, port_value, last, output ready);
endinterface

/* hdl/lcdf_cfg_regs.sv */
// APB-style configuration registers: bus width, nibble placement, held port half.
// Depends on lcdf_pkg.
module lcdf_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lcdf_pkg::CFG_AW-1:0] paddr,
  input  logic [lcdf_pkg::CFG_DW-1:0] pwdata,
  output logic [lcdf_pkg::CFG_DW-1:0] prdata,
  output logic                        pready,
  output lcdf_pkg::cfg_t              cfg
);
  import lcdf_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_AW-1:2];
  assign cfg     = cfg_r;

  // Register writes complete in the access cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bus_eight_bit   <= 1'b0;
      cfg_r.nibble_on_upper <= 1'b1;
      cfg_r.other_half_pins <= 4'd0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_BUS_EIGHT:    cfg_r.bus_eight_bit   <= pwdata[0];
        REG_NIBBLE_UPPER: cfg_r.nibble_on_upper <= pwdata[0];
        REG_OTHER_HALF:   cfg_r.other_half_pins <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    unique case (reg_idx)
      REG_BUS_EIGHT:    prdata = {{(CFG_DW-1){1'b0}}, cfg_r.bus_eight_bit};
      REG_NIBBLE_UPPER: prdata = {{(CFG_DW-1){1'b0}}, cfg_r.nibble_on_upper};
      REG_OTHER_HALF:   prdata = {{(CFG_DW-4){1'b0}}, cfg_r.other_half_pins};
      default:          prdata = '0;
    endcase
  end

endmodule

/* hdl/lcdf_sequencer.sv */
// Microprogram sequencer: step counter, control store lookup and jump logic.
// Depends on lcdf_pkg for the control store and its types.
module lcdf_sequencer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [1:0]           in_action,
  input  logic [1:0]           in_row,
  input  lcdf_pkg::dp_status_t status,
  output logic                 in_ready,
  output lcdf_pkg::op_t        op
);
  import lcdf_pkg::*;

  ua_t    upc_r;
  ua_t    upc_nxt;
  ua_t    upc_inc;
  ucode_t cw;
  logic   cond_hit;
  logic   stall;

  // Step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= UA_FETCH;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  // Decode the current control word and pick the next step.
  always_comb begin
    cw      = ucode_rom(upc_r);
    upc_inc = ua_t'(4'(upc_r + 4'd1));

    unique case (cw.cond)
      C_BUS8:        cond_hit = status.bus8;
      C_FINAL:       cond_hit = status.final_byte;
      C_DABBLE_MORE: cond_hit = status.dabble_more;
      C_LEAD_ZERO:   cond_hit = status.lead_zero;
      default:       cond_hit = 1'b0;
    endcase

    // A bus write waits until the output register can take it.
    stall    = ((cw.op == OP_EMIT_HI) || (cw.op == OP_EMIT_LO)) && !status.slot_free;
    in_ready = (cw.jmp == J_DISPATCH);
    op       = stall ? OP_NONE : cw.op;
    upc_nxt  = upc_r;

    if (!stall) begin
      unique case (cw.jmp)
        J_NEXT: upc_nxt = upc_inc;
        J_GOTO: upc_nxt = cw.target;
        J_IF:   upc_nxt = cond_hit ? cw.target : upc_inc;
        J_DISPATCH: begin
          if (!in_valid) begin
            op = OP_NONE;
          end else begin
            unique case (in_action)
              ACT_COMMAND, ACT_DATA: upc_nxt = UA_EMIT_HI;
              ACT_CURSOR: begin
                // Rows other than one and two produce no write.
                if ((in_row == ROW_FIRST) || (in_row == ROW_SECOND)) begin
                  upc_nxt = UA_EMIT_HI;
                end else begin
                  upc_nxt = UA_FETCH;
                end
              end
              ACT_NUMBER: upc_nxt = UA_DABBLE;
              default:    upc_nxt = UA_FETCH;
            endcase
          end
        end
        default: upc_nxt = UA_FETCH;
      endcase
    end
  end

endmodule

/* hdl/lcdf_datapath.sv */
// Datapath: request registers, shift-add-3 decimal converter, digit index and
// the output register of the bus-write channel. Depends on lcdf_pkg.
module lcdf_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lcdf_pkg::op_t               op,
  input  lcdf_pkg::cfg_t              cfg,
  input  logic [1:0]                  in_action,
  input  logic [7:0]                  in_byte,
  input  logic [1:0]                  in_row,
  input  logic [7:0]                  in_col,
  input  logic [lcdf_pkg::NUM_W-1:0]  in_number,
  input  logic                        out_ready,
  output lcdf_pkg::dp_status_t        status,
  output logic                        out_valid,
  output logic                        out_reg_select,
  output logic [7:0]                  out_port_value,
  output logic                        out_last
);
  import lcdf_pkg::*;

  localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(BCD_DIGITS - 1);
  localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_DIGITS - 1);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(NUM_W - 1);

  logic [1:0]       act_r;
  logic             rs_r;
  logic [7:0]       byte_r;
  logic [NUM_W-1:0] num_r;
  logic [3:0]       bcd_r [BCD_DIGITS];
  logic [3:0]       bcd_adj [BCD_DIGITS];
  logic [3:0]       bcd_nxt [BCD_DIGITS];
  logic [CNT_W-1:0] cnt_r;
  logic [IDX_W-1:0] idx_r;

  logic             out_valid_r;
  logic             out_rs_r;
  logic [7:0]       out_port_r;
  logic             out_last_r;

  logic [3:0]       cur_digit;
  logic             final_byte;
  logic             emit;
  logic [7:0]       hi_port;
  logic [7:0]       lo_port;
  logic [7:0]       cursor_byte;
  logic [3:0]       hold;

  assign cur_digit  = bcd_r[idx_r];
  assign final_byte = !((act_r == ACT_NUMBER) && (idx_r != '0));
  assign emit       = (op == OP_EMIT_HI) || (op == OP_EMIT_LO);
  assign hold       = cfg.other_half_pins;

  // Port values for the high and low halves of the current byte.
  always_comb begin
    if (cfg.bus_eight_bit) begin
      hi_port = byte_r;
    end else if (cfg.nibble_on_upper) begin
      hi_port = {byte_r[7:4], hold};
    end else begin
      hi_port = {hold, byte_r[7:4]};
    end
    lo_port = cfg.nibble_on_upper ? {byte_r[3:0], hold} : {hold, byte_r[3:0]};
  end

  // Set-address command for a cursor request; wraps modulo 256.
  assign cursor_byte = 8'(DDRAM_BASE + ((in_row == ROW_SECOND) ? ROW2_OFFSET : 8'd0)
                          + in_col - 8'd1);

  // One shift-add-3 step over all decimal digits.
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      bcd_adj[i] = (bcd_r[i] >= 4'd5) ? 4'(bcd_r[i] + 4'd3) : bcd_r[i];
    end
    bcd_nxt[0] = {bcd_adj[0][2:0], num_r[NUM_W-1]};
    for (int i = 1; i < BCD_DIGITS; i++) begin
      bcd_nxt[i] = {bcd_adj[i][2:0], bcd_adj[i-1][3]};
    end
  end

  // Status back to the sequencer.
  always_comb begin
    status.bus8        = cfg.bus_eight_bit;
    status.final_byte  = final_byte;
    status.dabble_more = (cnt_r != CNT_END);
    status.lead_zero   = (cur_digit == 4'd0) && (idx_r != '0);
    status.slot_free   = !out_valid_r || out_ready;
  end

  // Working registers, driven by the operation of the current step.
  always_ff @(posedge clk) begin
    unique case (op)
      OP_LOAD: begin
        act_r <= in_action;
        rs_r  <= (in_action == ACT_DATA) || (in_action == ACT_NUMBER);
        byte_r <= (in_action == ACT_CURSOR) ? cursor_byte : in_byte;
        num_r <= in_number;
        cnt_r <= '0;
        idx_r <= TOP_IDX;
        for (int i = 0; i < BCD_DIGITS; i++) begin
          bcd_r[i] <= 4'd0;
        end
      end
      OP_DABBLE: begin
        num_r <= {num_r[NUM_W-2:0], 1'b0};
        cnt_r <= CNT_W'(cnt_r + 1'b1);
        for (int i = 0; i < BCD_DIGITS; i++) begin
          bcd_r[i] <= bcd_nxt[i];
        end
      end
      OP_SCAN: begin
        if ((cur_digit == 4'd0) && (idx_r != '0)) begin
          idx_r <= IDX_W'(idx_r - 1'b1);
        end
      end
      OP_CLAMP: begin
        if (idx_r > MAX_IDX) begin
          idx_r <= MAX_IDX;
        end
      end
      OP_DIGIT:   byte_r <= 8'(ASCII_ZERO + {4'd0, cur_digit});
      OP_DEC_IDX: idx_r  <= IDX_W'(idx_r - 1'b1);
      default: ;
    endcase
  end

  // Output register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (op == OP_EMIT_HI) begin
      out_rs_r   <= rs_r;
      out_port_r <= hi_port;
      out_last_r <= cfg.bus_eight_bit && final_byte;
    end else if (op == OP_EMIT_LO) begin
      out_rs_r   <= rs_r;
      out_port_r <= lo_port;
      out_last_r <= final_byte;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_reg_select = out_rs_r;
  assign out_port_value = out_port_r;
  assign out_last       = out_last_r;

endmodule

/* hdl/char_lcd_write_formatter.sv */
// Channel  | Dir | Handshake    | Item
// in_ch    | in  | valid/ready  | action, byte_value, row_number, column_number, number_value
// out_ch   | out | valid/ready  | reg_select, port_value, last (one bus write)
// APB      | in  | psel/penable | bus_eight_bit @0x0, nibble_on_upper @0x4, other_half_pins @0x8
//
// Command, data and cursor items pass through the load, high-half write and after steps, with a
// low-half write between them on a 4-bit bus. A number first runs the binary to decimal loop,
// one bit per cycle, then the leading-zero scan and one microprogram pass per printed digit.
// A cursor item on another row produces no write.
// Synchronous active-low reset; a stall on out_ch holds the sequencer at its write step.
// Top level of the formatter; depends on lcdf_pkg, lcdf_ifs and the three submodules.
module char_lcd_write_formatter (
  input  logic                        clk,
  input  logic                        rst_n,
  lcdf_in_if.sink                     in_ch,
  lcdf_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lcdf_pkg::CFG_AW-1:0] paddr,
  input  logic [lcdf_pkg::CFG_DW-1:0] pwdata,
  output logic [lcdf_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import lcdf_pkg::*;

  cfg_t       cfg;
  op_t        op;
  dp_status_t status;

  // Configuration registers.
  lcdf_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Microprogram sequencer.
  lcdf_sequencer u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_row    (in_ch.row_number),
    .status    (status),
    .in_ready  (in_ch.ready),
    .op        (op)
  );

  // Datapath and output register.
  lcdf_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .op             (op),
    .cfg            (cfg),
    .in_action      (in_ch.action),
    .in_byte        (in_ch.byte_value),
    .in_row         (in_ch.row_number),
    .in_col         (in_ch.column_number),
    .in_number      (in_ch.number_value),
    .out_ready      (out_ch.ready),
    .status         (status),
    .out_valid      (out_ch.valid),
    .out_reg_select (out_ch.reg_select),
    .out_port_value (out_ch.port_value),
    .out_last       (out_ch.last)
  );

endmodule

/* hdl/lcdf_checker.sv */
// Port-level checks for the formatter, attached to the top level by a bind.
// Depends on lcdf_pkg for the action and row codes.
module lcdf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_action,
  input logic [1:0] in_row,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_reg_select,
  input logic [7:0] out_port_value,
  input logic       out_last
);
  import lcdf_pkg::*;

  logic in_acc;
  logic acc_writes;

  assign in_acc     = in_valid && in_ready;
  assign acc_writes = (in_action != ACT_CURSOR) || (in_row == ROW_FIRST) ||
                      (in_row == ROW_SECOND);

  // A stalled write stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("bus write dropped while stalled");

  // A stalled write keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_reg_select) && $stable(out_port_value) &&
                                $stable(out_last))
    else $error("bus write payload changed while stalled");

  // The sequencer is ready for an item right after reset.
  a_ready_after_reset: assert property (@(posedge clk)
    $past(!rst_n) && rst_n |-> in_ready)
    else $error("not ready after reset");

  // An item that produces writes keeps the block busy in the next cycle.
  a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && acc_writes |=> !in_ready)
    else $error("ready while an item is being written");

  // A cursor request on another row finishes at once.
  a_empty_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !acc_writes |=> in_ready)
    else $error("cursor request without writes held the block");

endmodule

bind char_lcd_write_formatter lcdf_checker u_lcdf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_action      (in_ch.action),
  .in_row         (in_ch.row_number),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_reg_select (out_ch.reg_select),
  .out_port_value (out_ch.port_value),
  .out_last       (out_ch.last)
);
